// ----- hdl/julia_escape_time_iterator_top_defines.svh -----
// Assertion macros for the Julia escape-time iterator
`ifndef JULIA_ESCAPE_TIME_ITERATOR_TOP_DEFINES_SVH
`define JULIA_ESCAPE_TIME_ITERATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent holds in this cycle -> consequent holds in the same cycle
`define JET_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("jet assertion failed");
// antecedent holds in this cycle -> consequent holds in the next cycle
`define JET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jet assertion failed");
`else
`define JET_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define JET_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/jet_pkg.sv -----
// Shared types, constants and saturation helpers for the Julia escape-time iterator
`timescale 1ns / 1ps
`default_nettype none

package jet_pkg;

    // Number formats
    localparam int WORD_W      = 32;
    localparam int FRAC_BITS   = 24;
    localparam int COUNT_WIDTH = 16;
    localparam int CNT_OUT_W   = 16;
    localparam int MAX_ITER_W  = 16;
    localparam int RAD_W       = 3;
    localparam int EXP_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int ACC_W       = 2 * WORD_W - FRAC_BITS + 2;
    localparam int MAG_W       = PROD_W + 1;
    localparam int RSQ_W       = 2 * RAD_W;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Register reset values
    localparam word_t                C_REAL_RST   = -32'sd13463717;
    localparam word_t                C_IMAG_RST   = 32'sd2617246;
    localparam logic [RAD_W-1:0]     RADIUS_RST   = 3'd2;
    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 16'd800;
    localparam logic [EXP_W-1:0]     EXP_RST      = 3'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_REAL   = 3'd0,
        REG_C_IMAG   = 3'd1,
        REG_RADIUS   = 3'd2,
        REG_MAX_ITER = 3'd3,
        REG_EXPONENT = 3'd4
    } reg_idx_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG_XX,
        ST_MAG_YY,
        ST_MAG_CHK,
        ST_SQ_XX,
        ST_SQ_YY,
        ST_SQ_XY,
        ST_SQ_WB,
        ST_ML_XBR,
        ST_ML_YBI,
        ST_ML_XBI,
        ST_ML_BRY,
        ST_ML_WB,
        ST_ADD_C,
        ST_FIN
    } state_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MS_XX,
        MS_YY,
        MS_XY,
        MS_XBR,
        MS_YBI,
        MS_XBI,
        MS_BRY
    } mul_sel_t;

    // Real accumulator operations
    typedef enum logic [1:0] {
        RE_HOLD,
        RE_LOAD,
        RE_SUB
    } re_op_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_z;
        logic     snap;
        mul_sel_t mul_sel;
        re_op_t   re_op;
        logic     im_load;
        logic     mag_load;
        logic     wb_sq;
        logic     wb_ml;
        logic     add_c;
        logic     emit;
        logic     emit_esc;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic                   mag_ge;
        logic                   at_limit;
        logic                   sat;
        logic [COUNT_WIDTH-1:0] count;
    } status_t;

    // True when v does not fit a signed word
    function automatic logic ovf_word(input acc_t v);
        logic [ACC_W-WORD_W:0] top;
        top      = v[ACC_W-1:WORD_W-1];
        ovf_word = !((&top) || !(|top));
    endfunction

    // Clamp v to the signed word range
    function automatic word_t clamp_word(input acc_t v);
        word_t r;
        if (!ovf_word(v)) begin
            r = v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        clamp_word = r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/jet_ctrl.sv -----
// Sequencing state machine for the escape-time iteration
`timescale 1ns / 1ps
`default_nettype none

module jet_ctrl (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              out_free,
    input  wire  [jet_pkg::EXP_W-1:0]        exponent,
    input  jet_pkg::status_t                 status,
    output jet_pkg::cmd_t                    cmd
);
    import jet_pkg::*;

    state_t state_reg, state_next;
    logic   bit_reg, bit_next;
    logic   esc_reg, esc_next;
    logic   bit_set;

    // exponent bit under test in the power loop
    assign bit_set = bit_reg ? exponent[1] : exponent[0];

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg   <= 1'b0;
            esc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            esc_reg   <= esc_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        esc_next   = esc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_MAG_XX;
                end
            end
            ST_MAG_XX:  state_next = ST_MAG_YY;
            ST_MAG_YY:  state_next = ST_MAG_CHK;
            ST_MAG_CHK: begin
                if (status.mag_ge) begin
                    esc_next   = !status.at_limit;
                    state_next = ST_FIN;
                end else if (status.at_limit) begin
                    esc_next   = 1'b0;
                    state_next = ST_FIN;
                end else if (exponent[2] || exponent[1]) begin
                    // first square reuses the magnitude products
                    bit_next   = exponent[2];
                    state_next = ST_SQ_WB;
                end else begin
                    state_next = ST_ADD_C;
                end
            end
            ST_SQ_XX: state_next = ST_SQ_YY;
            ST_SQ_YY: state_next = ST_SQ_XY;
            ST_SQ_XY: state_next = ST_SQ_WB;
            ST_SQ_WB: begin
                if (bit_set) begin
                    state_next = ST_ML_XBR;
                end else if (!bit_reg) begin
                    state_next = ST_ADD_C;
                end else begin
                    bit_next   = 1'b0;
                    state_next = ST_SQ_XX;
                end
            end
            ST_ML_XBR: state_next = ST_ML_YBI;
            ST_ML_YBI: state_next = ST_ML_XBI;
            ST_ML_XBI: state_next = ST_ML_BRY;
            ST_ML_BRY: state_next = ST_ML_WB;
            ST_ML_WB: begin
                if (!bit_reg) begin
                    state_next = ST_ADD_C;
                end else begin
                    bit_next   = 1'b0;
                    state_next = ST_SQ_XX;
                end
            end
            ST_ADD_C: begin
                if (status.sat) begin
                    esc_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_MAG_XX;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MS_XX;
        cmd.re_op    = RE_HOLD;
        cmd.emit_esc = esc_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.load_z = in_valid;
            end
            ST_MAG_XX: begin
                cmd.snap    = 1'b1;
                cmd.mul_sel = MS_XX;
            end
            ST_MAG_YY: begin
                cmd.mul_sel  = MS_YY;
                cmd.mag_load = 1'b1;
                cmd.re_op    = RE_LOAD;
            end
            ST_MAG_CHK: begin
                cmd.mul_sel = MS_XY;
                cmd.re_op   = RE_SUB;
            end
            ST_SQ_XX: cmd.mul_sel = MS_XX;
            ST_SQ_YY: begin
                cmd.mul_sel = MS_YY;
                cmd.re_op   = RE_LOAD;
            end
            ST_SQ_XY: begin
                cmd.mul_sel = MS_XY;
                cmd.re_op   = RE_SUB;
            end
            ST_SQ_WB:  cmd.wb_sq = 1'b1;
            ST_ML_XBR: cmd.mul_sel = MS_XBR;
            ST_ML_YBI: begin
                cmd.mul_sel = MS_YBI;
                cmd.re_op   = RE_LOAD;
            end
            ST_ML_XBI: begin
                cmd.mul_sel = MS_XBI;
                cmd.re_op   = RE_SUB;
            end
            ST_ML_BRY: begin
                cmd.mul_sel = MS_BRY;
                cmd.im_load = 1'b1;
            end
            ST_ML_WB: cmd.wb_ml = 1'b1;
            ST_ADD_C: cmd.add_c = 1'b1;
            ST_FIN:   cmd.emit  = out_free;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/jet_dp.sv -----
// Datapath: working point, shared multiplier, accumulators, magnitude test, counter
`timescale 1ns / 1ps
`default_nettype none

module jet_dp (
    input  wire                              aclk,
    input  jet_pkg::cmd_t                    cmd,
    input  jet_pkg::word_t                   start_real,
    input  jet_pkg::word_t                   start_imag,
    input  jet_pkg::word_t                   c_real,
    input  jet_pkg::word_t                   c_imag,
    input  wire  [jet_pkg::RAD_W-1:0]        escape_radius,
    input  wire  [jet_pkg::MAX_ITER_W-1:0]   max_iterations,
    output jet_pkg::status_t                 status
);
    import jet_pkg::*;

    word_t                  x_reg, y_reg, br_reg, bi_reg;
    word_t                  mul_a, mul_b;
    prod_t                  prod_reg, prod_next;
    acc_t                   acc_re_reg, acc_im_reg;
    logic [PROD_W-1:0]      mag_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   sat_reg;
    acc_t                   prod_fr, prod_fr1, im_sum, sum_x, sum_y;
    logic [MAG_W-1:0]       mag_sum, bound;
    logic [RSQ_W-1:0]       rsq;
    logic [COUNT_WIDTH-1:0] limit;
    logic                   add_ovf;

    // Operand select for the shared multiplier
    always_comb begin
        case (cmd.mul_sel)
            MS_XX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MS_YY: begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            MS_XY: begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            MS_XBR: begin
                mul_a = x_reg;
                mul_b = br_reg;
            end
            MS_YBI: begin
                mul_a = y_reg;
                mul_b = bi_reg;
            end
            MS_XBI: begin
                mul_a = x_reg;
                mul_b = bi_reg;
            end
            MS_BRY: begin
                mul_a = br_reg;
                mul_b = y_reg;
            end
            default: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Product rounded down to the fixed-point grid; imaginary square takes 2xy
    assign prod_fr  = acc_t'(prod_reg >>> FRAC_BITS);
    assign prod_fr1 = acc_t'(prod_reg >>> (FRAC_BITS - 1));
    assign im_sum   = acc_im_reg + prod_fr;

    // Adding the constant
    assign sum_x   = acc_t'(x_reg) + acc_t'(c_real);
    assign sum_y   = acc_t'(y_reg) + acc_t'(c_imag);
    assign add_ovf = ovf_word(sum_x) || ovf_word(sum_y);

    // Exact magnitude against radius squared
    assign rsq     = RSQ_W'(escape_radius) * RSQ_W'(escape_radius);
    assign bound   = MAG_W'(rsq) << (2 * FRAC_BITS);
    assign mag_sum = {1'b0, mag_reg} + {1'b0, prod_reg};
    assign limit   = COUNT_WIDTH'(max_iterations);

    assign status.mag_ge   = (mag_sum >= bound);
    assign status.at_limit = (count_reg >= limit);
    assign status.sat      = sat_reg || (cmd.add_c && add_ovf);
    assign status.count    = count_reg;

    // Multiplier output register
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // Accumulators and magnitude partial sum
    always_ff @(posedge aclk) begin
        case (cmd.re_op)
            RE_LOAD: acc_re_reg <= prod_fr;
            RE_SUB:  acc_re_reg <= acc_re_reg - prod_fr;
            default: acc_re_reg <= acc_re_reg;
        endcase
        if (cmd.im_load) begin
            acc_im_reg <= prod_fr;
        end
        if (cmd.mag_load) begin
            mag_reg <= prod_reg;
        end
    end

    // Working point, power-step base, counter and saturation flag
    always_ff @(posedge aclk) begin
        if (cmd.load_z) begin
            x_reg     <= start_real;
            y_reg     <= start_imag;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end else if (cmd.wb_sq) begin
            x_reg   <= clamp_word(acc_re_reg);
            y_reg   <= clamp_word(prod_fr1);
            sat_reg <= sat_reg || ovf_word(acc_re_reg) || ovf_word(prod_fr1);
        end else if (cmd.wb_ml) begin
            x_reg   <= clamp_word(acc_re_reg);
            y_reg   <= clamp_word(im_sum);
            sat_reg <= sat_reg || ovf_word(acc_re_reg) || ovf_word(im_sum);
        end else if (cmd.add_c) begin
            x_reg     <= clamp_word(sum_x);
            y_reg     <= clamp_word(sum_y);
            sat_reg   <= sat_reg || add_ovf;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.snap) begin
            br_reg <= x_reg;
            bi_reg <= y_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/julia_escape_time_iterator_top.sv -----
// Julia escape-time iterator: top level with register file and result register
//
// Input channel (s_*): one beat carries a starting point, signed Q8.24.
// Result channel (m_*): one beat per input, iteration count and escaped flag.
// Configuration channel (cfg_*): index and data; always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Each iteration z = z^p + c (z + c at exponent 0) runs on one shared 32x32
// multiplier, one product per cycle, in order: the magnitude test, the first
// square (on the magnitude products), each further square, each multiply by
// the base where the exponent bit is set, and the addition of c.
// One point is in work at a time; the next input beat is taken once the
// result sits in the output register, even while that result is stalled.
// A result waits in the output register as long as m_ready stays low.
// Reset (aresetn low, synchronous) empties the block and returns all
// configuration registers to their default values.
`timescale 1ns / 1ps
`default_nettype none
`include "julia_escape_time_iterator_top_defines.svh"

module julia_escape_time_iterator_top (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  jet_pkg::word_t                   s_start_real,
    input  jet_pkg::word_t                   s_start_imag,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [jet_pkg::CNT_OUT_W-1:0]    m_iteration_count,
    output logic                             m_escaped,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [jet_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [jet_pkg::WORD_W-1:0]       cfg_data
);
    import jet_pkg::*;

    word_t                  c_real_reg, c_imag_reg;
    logic [RAD_W-1:0]       radius_reg;
    logic [MAX_ITER_W-1:0]  max_iter_reg;
    logic [EXP_W-1:0]       exponent_reg;
    logic                   m_valid_reg;
    logic [CNT_OUT_W-1:0]   m_count_reg;
    logic                   m_esc_reg;
    logic                   out_free;
    cmd_t                   cmd;
    status_t                status;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg   <= C_REAL_RST;
            c_imag_reg   <= C_IMAG_RST;
            radius_reg   <= RADIUS_RST;
            max_iter_reg <= MAX_ITER_RST;
            exponent_reg <= EXP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_C_REAL:   c_real_reg   <= cfg_data;
                REG_C_IMAG:   c_imag_reg   <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                REG_MAX_ITER: max_iter_reg <= cfg_data[MAX_ITER_W-1:0];
                REG_EXPONENT: exponent_reg <= cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register frees the datapath while a result is stalled
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_count_reg <= CNT_OUT_W'(status.count);
            m_esc_reg   <= cmd.emit_esc;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign m_escaped         = m_esc_reg;

    // Controller
    jet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .exponent (exponent_reg),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    jet_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .start_real     (s_start_real),
        .start_imag     (s_start_imag),
        .c_real         (c_real_reg),
        .c_imag         (c_imag_reg),
        .escape_radius  (radius_reg),
        .max_iterations (max_iter_reg),
        .status         (status)
    );

    // A result is only written into a free output register
    `JET_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, (!m_valid_reg || m_ready))
    // One point at a time: input closes right after a beat
    `JET_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A new point starts with the counter at zero
    `JET_ASSERT_NEXT(a_count_clear, aclk, aresetn, s_valid && s_ready, status.count == '0)

endmodule

`default_nettype wire

// ----- tb/sv/tb_julia_escape_time_iterator_top.sv -----
// Self-checking testbench for the Julia escape-time iterator top level
`timescale 1ns / 1ps

module tb_julia_escape_time_iterator_top;
    import jet_pkg::*;

    localparam int     ONE_Q       = 1 << FRAC_BITS;
    localparam int     COORD_SPAN  = (5 * ONE_Q) / 2;
    localparam word_t  W_MAX       = 32'sh7FFFFFFF;
    localparam word_t  W_MIN       = 32'sh80000000;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam int     HOLD_CYCLES = 600;
    localparam int     CYCLE_LIMIT = 10000000;

    typedef struct packed {
        word_t re;
        word_t im;
    } point_t;

    typedef struct packed {
        word_t                  re;
        word_t                  im;
        logic [CNT_OUT_W-1:0]   count;
        logic                   esc;
    } orbit_result_t;

    // DUT signals
    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    word_t                s_start_real      = '0;
    word_t                s_start_imag      = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [CNT_OUT_W-1:0] m_iteration_count;
    logic                 m_escaped;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [WORD_W-1:0]    cfg_data          = '0;

    // Shadow copy of the configuration registers
    word_t                 julia_c_re = C_REAL_RST;
    word_t                 julia_c_im = C_IMAG_RST;
    logic [RAD_W-1:0]      esc_radius = RADIUS_RST;
    logic [MAX_ITER_W-1:0] iter_limit = MAX_ITER_RST;
    logic [EXP_W-1:0]      power_p    = EXP_RST;

    point_t        points_pending[$];
    orbit_result_t results_due[$];
    int            queued_total = 0;
    int            done_total   = 0;
    int            mismatches   = 0;
    int            cycle_count  = 0;
    logic          quiet        = 1'b0;
    logic          press_go     = 1'b0;
    bit            orbit_sat;

    julia_escape_time_iterator_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_real      (s_start_real),
        .s_start_imag      (s_start_imag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_escaped         (m_escaped),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Clamp to the signed word, flag any change
    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX) begin
            orbit_sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            orbit_sat = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // Q8.24 product, rounded toward minus infinity
    function automatic longint q_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    // Escape-time count for one starting point under the current settings
    function automatic orbit_result_t orbit_predict(input word_t sr, input word_t si);
        orbit_result_t     r;
        longint            x, y, bx, by, t, xx, yy;
        longint unsigned   mag, radius_sq;
        int unsigned       count, limit;
        int                lead_bit, b;
        bit                esc, done;
        x         = longint'(sr);
        y         = longint'(si);
        limit     = {16'd0, iter_limit};
        radius_sq = longint'(esc_radius) * longint'(esc_radius);
        radius_sq = radius_sq << FRAC_BITS;
        count     = 0;
        esc       = 1'b0;
        done      = 1'b0;
        while (!done) begin
            xx  = x * x;
            yy  = y * y;
            mag = xx;
            mag = mag + yy;
            if ((mag >> FRAC_BITS) >= radius_sq) begin
                esc  = (count < limit);
                done = 1'b1;
            end else if (count >= limit) begin
                done = 1'b1;
            end else begin
                orbit_sat = 1'b0;
                bx        = x;
                by        = y;
                lead_bit  = -1;
                for (b = 2; b >= 0; b--)
                    if (lead_bit < 0 && power_p[b]) lead_bit = b;
                // square, then multiply by the base where the bit is set
                for (b = lead_bit - 1; b >= 0; b--) begin
                    t = clamp_q(q_mul(x, x) - q_mul(y, y));
                    y = clamp_q((x * y) >>> (FRAC_BITS - 1));
                    x = t;
                    if (power_p[b]) begin
                        t = clamp_q(q_mul(x, bx) - q_mul(y, by));
                        y = clamp_q(q_mul(x, by) + q_mul(bx, y));
                        x = t;
                    end
                end
                x = clamp_q(x + julia_c_re);
                y = clamp_q(y + julia_c_im);
                count++;
                if (orbit_sat) begin
                    esc  = 1'b1;
                    done = 1'b1;
                end
            end
        end
        r.re    = sr;
        r.im    = si;
        r.count = count[CNT_OUT_W-1:0];
        r.esc   = esc;
        return r;
    endfunction

    // Mostly points around the set, some full-range words
    function automatic word_t pick_coord();
        int v;
        if ($urandom_range(0, 4) == 0) return $urandom;
        v = $urandom_range(0, 2 * COORD_SPAN);
        return v - COORD_SPAN;
    endfunction

    // Input driver: beats come from the pending queue
    int send_gap = 0;
    always @(posedge aclk) begin : point_driver
        point_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                results_due.push_back(orbit_predict(s_start_real, s_start_imag));
            if (s_valid && !s_ready) begin
                // beat still waiting, hold it
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (points_pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(0, 17);
                s_valid  <= 1'b0;
            end else begin
                nxt          = points_pending.pop_front();
                s_start_real <= nxt.re;
                s_start_imag <= nxt.im;
                s_valid      <= 1'b1;
            end
        end
    end

    // Result monitor with random back-pressure and one long hold-off
    int  recv_stall   = 0;
    int  hold_left    = 0;
    logic hold_started = 1'b0;
    always @(posedge aclk) begin : result_check
        orbit_result_t want;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            recv_stall   <= 0;
            hold_left    <= 0;
            hold_started <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result count=%0d escaped=%0b",
                             $time, m_iteration_count, m_escaped);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (m_iteration_count !== want.count) begin
                        $display("%0t: count for (%0d,%0d) expected %0d got %0d", $time,
                                 want.re, want.im, want.count, m_iteration_count);
                        mismatches++;
                    end
                    if (m_escaped !== want.esc) begin
                        $display("%0t: escaped for (%0d,%0d) expected %0b got %0b", $time,
                                 want.re, want.im, want.esc, m_escaped);
                        mismatches++;
                    end
                    done_total <= done_total + 1;
                end
            end
            if (press_go && !hold_started) begin
                hold_started <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                recv_stall <= $urandom_range(0, 17);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One register beat; valid is lowered by the caller after the last one
    task automatic write_reg(input reg_idx_t idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_C_REAL:   julia_c_re = val;
            REG_C_IMAG:   julia_c_im = val;
            REG_RADIUS:   esc_radius = val[RAD_W-1:0];
            REG_MAX_ITER: iter_limit = val[MAX_ITER_W-1:0];
            REG_EXPONENT: power_p    = val[EXP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input word_t cr, input word_t ci, input logic [RAD_W-1:0] rad,
                              input logic [MAX_ITER_W-1:0] lim, input logic [EXP_W-1:0] pw);
        write_reg(REG_C_REAL, cr);
        write_reg(REG_C_IMAG, ci);
        write_reg(REG_RADIUS, WORD_W'(rad));
        write_reg(REG_MAX_ITER, WORD_W'(lim));
        write_reg(REG_EXPONENT, WORD_W'(pw));
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_point(input word_t re, input word_t im);
        points_pending.push_back('{re: re, im: im});
        queued_total++;
    endtask

    // Block is idle once every queued point has returned its result
    task automatic wait_idle();
        while (done_total != queued_total) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Main sequence
    initial begin : stimulus
        int    ph, n, v;
        word_t cr, ci;
        logic [RAD_W-1:0]      rad;
        logic [MAX_ITER_W-1:0] lim;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: origin, on and just inside the radius, word extremes
        queue_point(0, 0);
        queue_point(2 * ONE_Q, 0);
        queue_point(2 * ONE_Q - 1, 0);
        queue_point(0, -2 * ONE_Q);
        queue_point(W_MAX, W_MAX);
        queue_point(W_MIN, W_MIN);
        queue_point(W_MIN, W_MAX);
        queue_point(W_MAX, W_MIN);
        queue_point(ONE_Q / 4, ONE_Q / 8);
        queue_point(-1, -1);
        wait_idle();

        // saturation on the only permitted iteration, limit reached with c at extremes
        set_config(W_MIN, W_MAX, 3'd7, 16'd1, 3'd4);
        queue_point(5 * ONE_Q, 0);
        queue_point(0, 0);
        queue_point(ONE_Q, ONE_Q);
        wait_idle();

        // limit zero
        set_config(W_MAX, W_MIN, 3'd7, 16'd0, 3'd7);
        queue_point(0, 0);
        queue_point(W_MAX, W_MAX);
        wait_idle();

        // radius zero, exponent zero
        set_config(0, 0, 3'd0, 16'd5, 3'd0);
        queue_point(0, 0);
        queue_point(ONE_Q, -ONE_Q);
        wait_idle();

        // exponent one: z + c walks out of the disc
        set_config(ONE_Q / 4, 0, 3'd4, 16'd30, 3'd1);
        queue_point(0, 0);
        wait_idle();

        // largest limit with points that leave quickly
        set_config(C_REAL_RST, C_IMAG_RST, 3'd2, 16'hFFFF, 3'd2);
        queue_point(3 * ONE_Q, 0);
        queue_point(-3 * ONE_Q, -3 * ONE_Q);
        queue_point(20132659, ONE_Q / 2);
        wait_idle();

        // receiver holds off long enough for the input to back up
        set_config(C_REAL_RST, C_IMAG_RST, 3'd2, 16'd4, 3'd2);
        press_go <= 1'b1;
        for (n = 0; n < 12; n++) begin
            v = $urandom_range(0, 2 * ONE_Q);
            queue_point(v - ONE_Q, pick_coord());
        end
        wait_idle();

        // random settings, one exponent per phase; last phase runs without idling
        for (ph = 0; ph < 9; ph++) begin
            if (ph == 8) quiet <= 1'b1;
            if (ph == 0) begin
                set_config(C_REAL_RST, C_IMAG_RST, RADIUS_RST, MAX_ITER_RST, EXP_RST);
            end else begin
                v  = $urandom_range(0, 2 * ONE_Q);
                cr = ($urandom_range(0, 2) == 0) ? word_t'($urandom) : word_t'(v - ONE_Q);
                v  = $urandom_range(0, 2 * ONE_Q);
                ci = ($urandom_range(0, 2) == 0) ? word_t'($urandom) : word_t'(v - ONE_Q);
                rad = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom_range(0, 7))
                                                  : RAD_W'($urandom_range(1, 4));
                lim = ($urandom_range(0, 5) == 0) ? MAX_ITER_W'($urandom_range(0, 3))
                                                  : MAX_ITER_W'($urandom_range(4, 60));
                set_config(cr, ci, rad, lim, EXP_W'((ph - 1) % 8));
            end
            for (n = 0; n < ((ph == 0) ? 15 : 42); n++)
                queue_point(pick_coord(), pick_coord());
            wait_idle();
        end

        repeat (60) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (results_due.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, results_due.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- julia_escape_time_iterator_top.f -----
+incdir+hdl
hdl/jet_pkg.sv
hdl/jet_ctrl.sv
hdl/jet_dp.sv
hdl/julia_escape_time_iterator_top.sv
tb/sv/tb_julia_escape_time_iterator_top.sv
